/* src/wps_pkg.sv */
// Shared types and constants for the WAVE PCM stream parser.
// Used by every module under src except wps_in_stage; depends on nothing.
package wps_pkg;

    // parser phases
    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
    localparam logic [2:0] PH_SKIP      = 3'd2;
    localparam logic [2:0] PH_DATA      = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;
    localparam logic [2:0] PH_FAILED    = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_BAD_TAG     = 3'd0;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd2;
    localparam logic [2:0] ERR_ZERO_CHAN   = 3'd3;
    localparam logic [2:0] ERR_SHORT_FMT   = 3'd4;

    // chunk tags, big-endian as they arrive
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] PCM_FORMAT   = 16'd1;
    localparam logic [15:0] DEPTH_8      = 16'd8;
    localparam logic [15:0] DEPTH_16     = 16'd16;
    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [7:0]  PCM8_OFFSET  = 8'h80;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] sample;
        logic        last_sample;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [4:0]  bit_depth;
        logic [2:0]  error_code;
    } t_result;

endpackage

/* src/wps_in_stage.sv */
// Input register of the WAVE PCM stream parser.
// Holds one accepted byte until the parser consumes it; uses nothing else.
module wps_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_file_byte,
    input  logic       i_end_of_file,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_file_byte,
    output logic       o_end_of_file
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eof;
    logic       w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_file_byte;
            r_eof  <= i_end_of_file;
        end
    end

    assign o_valid       = r_valid;
    assign o_file_byte   = r_byte;
    assign o_end_of_file = r_eof;
endmodule

/* src/wps_parser.sv */
// Parser state and per-byte update for the WAVE PCM stream parser.
// Depends on wps_pkg for phases, tags, codes and the result struct.
module wps_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_file_byte,
    input  logic             i_end_of_file,
    output wps_pkg::t_result o_result
);
    import wps_pkg::*;

    logic [2:0]  r_phase,  n_phase;
    logic [5:0]  r_pos,    n_pos;
    logic [31:0] r_rate,   n_rate;
    logic [15:0] r_chan,   n_chan;
    logic [15:0] r_bits,   n_bits;
    logic [15:0] r_fmt,    n_fmt;
    logic [31:0] r_tag,    n_tag;
    logic [31:0] r_left,   n_left;
    logic [15:0] r_chidx,  n_chidx;
    logic [7:0]  r_low,    n_low;
    logic        r_bis,    n_bis;
    logic        r_tag_ok, n_tag_ok;

    t_result     w_res;
    logic        w_bps2;
    logic [16:0] w_frame;
    logic [31:0] w_left_dec;
    logic [32:0] w_start_left;
    logic [15:0] w_chidx_inc;
    logic [31:0] w_fmt_left;
    logic [1:0]  w_k;

    assign w_bps2       = (r_bits == DEPTH_16);
    assign w_frame      = w_bps2 ? {r_chan, 1'b0} : {1'b0, r_chan};
    assign w_left_dec   = r_left - 32'd1;
    assign w_start_left = {1'b0, w_left_dec} + (w_bps2 ? 33'd2 : 33'd1);
    assign w_chidx_inc  = r_chidx + 16'd1;
    assign w_k          = r_pos[1:0];

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_rate     = r_rate;
        n_chan     = r_chan;
        n_bits     = r_bits;
        n_fmt      = r_fmt;
        n_tag      = r_tag;
        n_left     = r_left;
        n_chidx    = r_chidx;
        n_low      = r_low;
        n_bis      = r_bis;
        n_tag_ok   = r_tag_ok;
        w_res      = '0;
        w_fmt_left = r_left - FMT_MIN_SIZE;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos < 6'd4 || (r_pos >= 6'd8 && r_pos < 6'd16)) begin
                    n_tag = {r_tag[23:0], i_file_byte};
                    if (r_pos == 6'd3 && n_tag != TAG_RIFF) n_tag_ok = 1'b0;
                    if (r_pos == 6'd11 && n_tag != TAG_WAVE) n_tag_ok = 1'b0;
                    if (r_pos == 6'd15 && n_tag != TAG_FMT) n_tag_ok = 1'b0;
                end else if (r_pos >= 6'd16 && r_pos < 6'd20) begin
                    // offsets 16, 20 and 24 are multiples of four: low bits give the lane
                    n_left = (w_k == 2'd0) ? {24'd0, i_file_byte}
                           : (r_left | ({24'd0, i_file_byte} << {w_k, 3'b000}));
                end else if (r_pos >= 6'd20 && r_pos < 6'd22) begin
                    n_fmt = r_pos[0] ? {i_file_byte, r_fmt[7:0]} : {8'd0, i_file_byte};
                end else if (r_pos >= 6'd22 && r_pos < 6'd24) begin
                    n_chan = r_pos[0] ? {i_file_byte, r_chan[7:0]} : {8'd0, i_file_byte};
                end else if (r_pos >= 6'd24 && r_pos < 6'd28) begin
                    n_rate = (w_k == 2'd0) ? {24'd0, i_file_byte}
                           : (r_rate | ({24'd0, i_file_byte} << {w_k, 3'b000}));
                end else if (r_pos >= 6'd34 && r_pos < 6'd36) begin
                    n_bits = r_pos[0] ? {i_file_byte, r_bits[7:0]} : {8'd0, i_file_byte};
                end

                if (r_pos != 6'd35) begin
                    n_pos = r_pos + 6'd1;
                end else begin
                    // header complete: checks in priority order
                    priority if (!n_tag_ok) begin
                        w_res.valid      = 1'b1;
                        w_res.kind       = KIND_ERROR;
                        w_res.error_code = ERR_BAD_TAG;
                        n_phase          = PH_FAILED;
                    end else if (n_fmt != PCM_FORMAT
                                 || (n_bits != DEPTH_8 && n_bits != DEPTH_16)) begin
                        w_res.valid      = 1'b1;
                        w_res.kind       = KIND_ERROR;
                        w_res.error_code = ERR_UNSUPPORTED;
                        n_phase          = PH_FAILED;
                    end else if (n_chan == 16'd0) begin
                        w_res.valid      = 1'b1;
                        w_res.kind       = KIND_ERROR;
                        w_res.error_code = ERR_ZERO_CHAN;
                        n_phase          = PH_FAILED;
                    end else if (r_left < FMT_MIN_SIZE) begin
                        w_res.valid      = 1'b1;
                        w_res.kind       = KIND_ERROR;
                        w_res.error_code = ERR_SHORT_FMT;
                        n_phase          = PH_FAILED;
                    end else begin
                        w_res.valid         = 1'b1;
                        w_res.kind          = KIND_FORMAT;
                        w_res.sample_rate   = r_rate;
                        w_res.channel_count = r_chan;
                        w_res.bit_depth     = n_bits[4:0];
                        n_left              = w_fmt_left;
                        n_pos               = 6'd0;
                        n_phase = (w_fmt_left == 32'd0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
            end

            PH_CHUNK_HDR: begin
                if (!r_pos[2]) begin
                    n_tag = {r_tag[23:0], i_file_byte};
                end else begin
                    n_left = (w_k == 2'd0) ? {24'd0, i_file_byte}
                           : (r_left | ({24'd0, i_file_byte} << {w_k, 3'b000}));
                end
                if (r_pos[2:0] != 3'd7) begin
                    n_pos = {3'd0, r_pos[2:0] + 3'd1};
                end else begin
                    n_pos = 6'd0;
                    if (r_tag == TAG_DATA) begin
                        if (n_left < {15'd0, w_frame}) begin
                            w_res.valid = 1'b1;
                            w_res.kind  = KIND_EMPTY;
                            n_phase     = PH_DONE;
                        end else begin
                            n_phase = PH_DATA;
                            n_chidx = 16'd0;
                            n_bis   = 1'b0;
                        end
                    end else begin
                        n_phase = (n_left == 32'd0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
            end

            PH_SKIP: begin
                n_left = w_left_dec;
                if (w_left_dec == 32'd0) begin
                    n_phase = PH_CHUNK_HDR;
                    n_pos   = 6'd0;
                end
            end

            PH_DATA: begin
                n_left = w_left_dec;
                if (r_chidx == 16'd0) begin
                    if (w_bps2 && !r_bis) begin
                        n_low = i_file_byte;
                    end else begin
                        w_res.valid  = 1'b1;
                        w_res.kind   = KIND_SAMPLE;
                        w_res.sample = w_bps2 ? {i_file_byte, r_low}
                                              : {i_file_byte ^ PCM8_OFFSET, 8'd0};
                        w_res.last_sample = (w_start_left < {15'd0, w_frame, 1'b0});
                    end
                end
                if (w_bps2 && !r_bis) begin
                    n_bis = 1'b1;
                end else begin
                    n_bis = 1'b0;
                    if (w_chidx_inc >= r_chan) begin
                        n_chidx = 16'd0;
                        if (w_left_dec < {15'd0, w_frame}) n_phase = PH_DONE;
                    end else begin
                        n_chidx = w_chidx_inc;
                    end
                end
            end

            default: begin
            end
        endcase

        if (i_end_of_file) begin
            // truncation error unless an error already stands or the stream ended cleanly
            if (!(w_res.valid && w_res.kind == KIND_ERROR)
                && n_phase != PH_DONE && n_phase != PH_FAILED) begin
                w_res            = '0;
                w_res.valid      = 1'b1;
                w_res.kind       = KIND_ERROR;
                w_res.error_code = ERR_TRUNCATED;
            end
            n_phase  = PH_HEADER;
            n_pos    = 6'd0;
            n_rate   = 32'd0;
            n_chan   = 16'd0;
            n_bits   = 16'd0;
            n_fmt    = 16'd0;
            n_tag    = 32'd0;
            n_left   = 32'd0;
            n_chidx  = 16'd0;
            n_low    = 8'd0;
            n_bis    = 1'b0;
            n_tag_ok = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 6'd0;
            r_rate   <= 32'd0;
            r_chan   <= 16'd0;
            r_bits   <= 16'd0;
            r_fmt    <= 16'd0;
            r_tag    <= 32'd0;
            r_left   <= 32'd0;
            r_chidx  <= 16'd0;
            r_low    <= 8'd0;
            r_bis    <= 1'b0;
            r_tag_ok <= 1'b1;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_rate   <= n_rate;
            r_chan   <= n_chan;
            r_bits   <= n_bits;
            r_fmt    <= n_fmt;
            r_tag    <= n_tag;
            r_left   <= n_left;
            r_chidx  <= n_chidx;
            r_low    <= n_low;
            r_bis    <= n_bis;
            r_tag_ok <= n_tag_ok;
        end
    end

    assign o_result = w_res;
endmodule

/* src/wps_out_stage.sv */
// Result register of the WAVE PCM stream parser.
// Depends on wps_pkg for the result struct.
module wps_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  wps_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output wps_pkg::t_result o_result
);
    import wps_pkg::*;

    logic    r_valid;
    t_result r_res;

    // slot is free when empty or when its beat leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_result.valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_result.valid) begin
            r_res <= i_result;
        end
    end

    always_comb begin
        o_result       = r_res;
        o_result.valid = r_valid;
    end
endmodule

/* src/wav_pcm_stream_parser.sv */
// WAVE PCM stream parser, top level: input register, parser, result register.
// Depends on wps_pkg, wps_in_stage, wps_parser and wps_out_stage.
//
// Feed the file one byte per beat, with end_of_file on its final byte; the
// parser sustains one byte per cycle while results are taken. All header
// checks, chunk skipping and sample conversion are done combinationally from
// the byte held in the input register, against the parser's state registers;
// the result register behind it lets one more byte enter while a result waits
// to be taken. A header byte that completes the fmt block yields the format
// info (or an error), each whole frame yields its first-channel sample, and
// after end_of_file the parser starts over with the next byte. No clearing
// pass is needed after reset.
module wav_pcm_stream_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_file_byte,
    input  logic               i_end_of_file,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample,
    output logic               o_last_sample,
    output logic [31:0]        o_sample_rate,
    output logic [15:0]        o_channel_count,
    output logic [4:0]         o_bit_depth,
    output logic [2:0]         o_error_code
);
    import wps_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_in_eof;
    logic       w_out_free;
    logic       w_fire;
    t_result    w_step_res;
    t_result    w_out_res;

    assign w_fire = w_in_valid && w_out_free;

    wps_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_file_byte   (i_file_byte),
        .i_end_of_file (i_end_of_file),
        .i_take        (w_fire),
        .o_stall       (o_stall),
        .o_valid       (w_in_valid),
        .o_file_byte   (w_in_byte),
        .o_end_of_file (w_in_eof)
    );

    wps_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_file_byte   (w_in_byte),
        .i_end_of_file (w_in_eof),
        .o_result      (w_step_res)
    );

    wps_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_result (w_step_res),
        .i_stall  (i_stall),
        .o_free   (w_out_free),
        .o_result (w_out_res)
    );

    assign o_valid         = w_out_res.valid;
    assign o_kind          = w_out_res.kind;
    assign o_sample        = w_out_res.sample;
    assign o_last_sample   = w_out_res.last_sample;
    assign o_sample_rate   = w_out_res.sample_rate;
    assign o_channel_count = w_out_res.channel_count;
    assign o_bit_depth     = w_out_res.bit_depth;
    assign o_error_code    = w_out_res.error_code;
endmodule

/* bench/wav_pcm_stream_parser_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for wav_pcm_stream_parser: builds WAVE files byte by byte, predicts
// every result in step with accepted beats and checks each one as it leaves the block.
// Depends on wps_pkg and the RTL under src.
module wav_pcm_stream_parser_tb;
    import wps_pkg::*;

    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_JUNK = 32'h4A55_4E4B;
    localparam int          HDR_LAST = 35;   // final byte of the fixed 36-byte header

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] fmt_tag;
        logic [31:0] fmt_size;
        logic [15:0] format;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [7:0]  extra_fmt;
        logic [7:0]  n_fill;
        logic        zero_chunk;
        logic        huge_fill;
        logic [31:0] data_size;
        logic [31:0] data_len;
        logic [7:0]  trail;
    } wav_spec_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_file_byte = 8'd0;
    logic               i_end_of_file = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_kind;
    logic signed [15:0] o_sample;
    logic               o_last_sample;
    logic [31:0]        o_sample_rate;
    logic [15:0]        o_channel_count;
    logic [4:0]         o_bit_depth;
    logic [2:0]         o_error_code;

    wav_pcm_stream_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_file_byte     (i_file_byte),
        .i_end_of_file   (i_end_of_file),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_sample        (o_sample),
        .o_last_sample   (o_last_sample),
        .o_sample_rate   (o_sample_rate),
        .o_channel_count (o_channel_count),
        .o_bit_depth     (o_bit_depth),
        .o_error_code    (o_error_code)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // parser state mirrored by the predictor
    logic [2:0]  m_phase;
    logic [31:0] m_pos;
    logic [31:0] m_rate;
    logic [15:0] m_chans;
    logic [15:0] m_bits;
    logic [31:0] m_tag;
    logic [31:0] m_left;
    logic [15:0] m_chan_idx;
    logic [7:0]  m_low;
    logic        m_hi_byte;
    logic        m_tags_ok;
    logic [15:0] m_fmt;

    t_result     pending_results[$];
    byte_q_t     file_bytes;
    t_result     want;
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          results_seen = 0;
    int          n_kind[4] = '{0, 0, 0, 0};
    int          burst_left = 0;
    int          stall_hold = 0;
    int          rx_left = 0;
    int          rx_tick = 0;
    rx_mode_t    rx_mode = RX_OPEN;

    task automatic model_reset();
        m_phase    = PH_HEADER;
        m_pos      = '0;
        m_rate     = '0;
        m_chans    = '0;
        m_bits     = '0;
        m_tag      = '0;
        m_left     = '0;
        m_chan_idx = '0;
        m_low      = '0;
        m_hi_byte  = 1'b0;
        m_tags_ok  = 1'b1;
        m_fmt      = '0;
    endtask

    function automatic logic [31:0] put_le(input logic [31:0] cur, input logic [31:0] k,
                                           input logic [7:0] b);
        if (k == 0)
            return {24'd0, b};
        return cur | ({24'd0, b} << (8 * k[1:0]));
    endfunction

    function automatic t_result make_result(input logic [1:0] kind, input logic [15:0] smp,
                                            input logic last, input logic [31:0] rate,
                                            input logic [15:0] ch, input logic [4:0] depth,
                                            input logic [2:0] err);
        t_result r;
        r.valid         = 1'b1;
        r.kind          = kind;
        r.sample        = smp;
        r.last_sample   = last;
        r.sample_rate   = rate;
        r.channel_count = ch;
        r.bit_depth     = depth;
        r.error_code    = err;
        return r;
    endfunction

    // Advance the predicted parser by one byte; got says whether a result is due.
    task automatic parse_byte(input logic [7:0] b, input logic eof, output bit got,
                              output t_result r);
        logic [31:0] p;
        logic [31:0] frame;
        logic [31:0] bps;
        logic [63:0] start_left;
        logic [2:0]  err;
        logic [15:0] smp;
        bit          bad;
        got   = 1'b0;
        r     = '0;
        bps   = {16'd0, m_bits >> 3};
        frame = {16'd0, m_bits >> 3} * {16'd0, m_chans};
        case (m_phase)
            PH_HEADER: begin
                p = m_pos;
                if (p < 4 || (p >= 8 && p < 16)) begin
                    m_tag = {m_tag[23:0], b};
                    if ((p == 3 && m_tag != TAG_RIFF) || (p == 11 && m_tag != TAG_WAVE) ||
                        (p == 15 && m_tag != TAG_FMT))
                        m_tags_ok = 1'b0;
                end else if (p >= 16 && p < 20) begin
                    m_left = put_le(m_left, p - 16, b);
                end else if (p >= 20 && p < 22) begin
                    m_fmt = 16'(put_le({16'd0, m_fmt}, p - 20, b));
                end else if (p >= 22 && p < 24) begin
                    m_chans = 16'(put_le({16'd0, m_chans}, p - 22, b));
                end else if (p >= 24 && p < 28) begin
                    m_rate = put_le(m_rate, p - 24, b);
                end else if (p >= 34 && p < 36) begin
                    m_bits = 16'(put_le({16'd0, m_bits}, p - 34, b));
                end
                if (p != HDR_LAST) begin
                    m_pos = p + 1;
                end else begin
                    // checks run in priority order; the first failure wins
                    bad = 1'b1;
                    err = ERR_BAD_TAG;
                    if (!m_tags_ok)
                        err = ERR_BAD_TAG;
                    else if (m_fmt != PCM_FORMAT || (m_bits != DEPTH_8 && m_bits != DEPTH_16))
                        err = ERR_UNSUPPORTED;
                    else if (m_chans == 0)
                        err = ERR_ZERO_CHAN;
                    else if (m_left < FMT_MIN_SIZE)
                        err = ERR_SHORT_FMT;
                    else
                        bad = 1'b0;
                    got = 1'b1;
                    if (bad) begin
                        m_phase = PH_FAILED;
                        r = make_result(KIND_ERROR, '0, 1'b0, '0, '0, '0, err);
                    end else begin
                        r = make_result(KIND_FORMAT, '0, 1'b0, m_rate, m_chans, m_bits[4:0],
                                        '0);
                        m_left  = m_left - FMT_MIN_SIZE;
                        m_pos   = '0;
                        m_phase = (m_left == 0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
            end
            PH_CHUNK_HDR: begin
                p = {29'd0, m_pos[2:0]};
                if (p < 4)
                    m_tag = {m_tag[23:0], b};
                else
                    m_left = put_le(m_left, p - 4, b);
                if (p != 7) begin
                    m_pos = p + 1;
                end else begin
                    m_pos = '0;
                    if (m_tag == TAG_DATA) begin
                        if (m_left < frame) begin
                            m_phase = PH_DONE;
                            got = 1'b1;
                            r = make_result(KIND_EMPTY, '0, 1'b0, '0, '0, '0, '0);
                        end else begin
                            m_phase    = PH_DATA;
                            m_chan_idx = '0;
                            m_hi_byte  = 1'b0;
                        end
                    end else begin
                        m_phase = (m_left == 0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                m_left = m_left - 1;
                if (m_left == 0) begin
                    m_phase = PH_CHUNK_HDR;
                    m_pos   = '0;
                end
            end
            PH_DATA: begin
                m_left = m_left - 1;
                if (m_chan_idx == 0) begin
                    if (bps == 2 && !m_hi_byte) begin
                        m_low = b;
                    end else begin
                        smp = (bps == 2) ? {b, m_low} : {b ^ PCM8_OFFSET, 8'h00};
                        start_left = {32'd0, m_left} + {32'd0, bps};
                        got = 1'b1;
                        r = make_result(KIND_SAMPLE, smp, start_left < ({32'd0, frame} << 1),
                                        '0, '0, '0, '0);
                    end
                end
                if (bps == 2 && !m_hi_byte) begin
                    m_hi_byte = 1'b1;
                end else begin
                    m_hi_byte  = 1'b0;
                    m_chan_idx = m_chan_idx + 16'd1;
                    if (m_chan_idx >= m_chans) begin
                        m_chan_idx = '0;
                        if (m_left < frame)
                            m_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase
        if (eof) begin
            // an error raised by this very byte is kept
            if (!(got && r.kind == KIND_ERROR) && m_phase != PH_DONE && m_phase != PH_FAILED) begin
                got = 1'b1;
                r = make_result(KIND_ERROR, '0, 1'b0, '0, '0, '0, ERR_TRUNCATED);
            end
            model_reset();
        end
    endtask

    // Offer one beat, hold it until accepted, then predict its result.
    task automatic send_beat(input logic [7:0] b, input logic eof);
        int      gap;
        bit      got;
        t_result r;
        if (burst_left == 0) begin
            gap = 0;
            if ($urandom_range(3) == 0) begin
                burst_left = $urandom_range(200, 50);
            end else begin
                burst_left = $urandom_range(8, 1);
                gap = $urandom_range(6, 1);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_file_byte   <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_byte(b, eof, got, r);
        if (got) begin
            pending_results.push_back(r);
            n_kind[r.kind]++;
        end
        bytes_sent++;
    endtask

    // Send the first len bytes of the file (all when len is 0) with end_of_file on the last.
    task automatic send_file(input int len);
        int i;
        if (len <= 0 || len > file_bytes.size())
            len = file_bytes.size();
        for (i = 0; i < len; i++)
            send_beat(file_bytes[i], i == len - 1);
        files_sent++;
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        int i;
        for (i = 0; i < n; i++)
            file_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic push_tag(input logic [31:0] tag);
        int i;
        for (i = 3; i >= 0; i--)
            file_bytes.push_back(tag[8 * i +: 8]);
    endtask

    function automatic wav_spec_t base_spec(input logic [15:0] bits, input logic [15:0] chans,
                                            input int frames);
        wav_spec_t   s;
        logic [31:0] frame;
        frame       = {16'd0, bits >> 3} * {16'd0, chans};
        s           = '0;
        s.riff_tag  = TAG_RIFF;
        s.wave_tag  = TAG_WAVE;
        s.fmt_tag   = TAG_FMT;
        s.fmt_size  = FMT_MIN_SIZE;
        s.format    = PCM_FORMAT;
        s.chans     = chans;
        s.bits      = bits;
        s.rate      = $urandom;
        s.data_size = frame * frames;
        s.data_len  = s.data_size;
        return s;
    endfunction

    task automatic build_file(input wav_spec_t s);
        int          i;
        int          sz;
        logic [31:0] tag;
        file_bytes.delete();
        push_tag(s.riff_tag);
        push_le($urandom, 4);
        push_tag(s.wave_tag);
        push_tag(s.fmt_tag);
        push_le(s.fmt_size, 4);
        push_le(32'(s.format), 2);
        push_le(32'(s.chans), 2);
        push_le(s.rate, 4);
        push_le($urandom, 6);   // byte rate and block align are not checked
        push_le(32'(s.bits), 2);
        repeat (s.extra_fmt) file_bytes.push_back(8'($urandom));
        if (s.zero_chunk) begin
            push_tag(TAG_JUNK);
            push_le(32'd0, 4);
        end
        for (i = 0; i < s.n_fill; i++) begin
            tag = $urandom_range(1) ? TAG_LIST : $urandom;
            if (tag == TAG_DATA)
                tag = TAG_LIST;
            sz = $urandom_range(5);
            push_tag(tag);
            push_le(sz, 4);
            repeat (sz) file_bytes.push_back(8'($urandom));
        end
        if (s.huge_fill) begin
            // a chunk far longer than the file: the parser is left skipping
            push_tag(TAG_JUNK);
            push_le($urandom | 32'h8000_0000, 4);
            repeat (3) file_bytes.push_back(8'($urandom));
        end else begin
            push_tag(TAG_DATA);
            push_le(s.data_size, 4);
            repeat (s.data_len) file_bytes.push_back(8'($urandom));
        end
        repeat (s.trail) file_bytes.push_back(8'($urandom));
    endtask

    task automatic test_pcm8_mono();
        wav_spec_t s;
        int        n;
        s = base_spec(DEPTH_8, 16'd1, 4);
        build_file(s);
        n = file_bytes.size();
        // offset-binary extremes and both sides of the midpoint
        file_bytes[n - 4] = 8'h00;
        file_bytes[n - 3] = 8'h7F;
        file_bytes[n - 2] = 8'h80;
        file_bytes[n - 1] = 8'hFF;
        // bytes after the last frame are dropped without error
        repeat (3) file_bytes.push_back(8'($urandom));
        send_file(0);
    endtask

    task automatic test_pcm16_stereo();
        wav_spec_t s;
        int        ds;
        s = base_spec(DEPTH_16, 16'd2, 4);
        s.rate       = 32'hFFFF_FFFF;
        s.fmt_size   = 32'd18;
        s.extra_fmt  = 8'd2;
        s.n_fill     = 8'd1;
        s.zero_chunk = 1'b1;
        s.data_size  = s.data_size + 3;   // trailing partial frame
        s.data_len   = s.data_size;
        build_file(s);
        ds = file_bytes.size() - s.data_len;
        file_bytes[ds + 0]  = 8'h00;
        file_bytes[ds + 1]  = 8'h80;
        file_bytes[ds + 4]  = 8'hFF;
        file_bytes[ds + 5]  = 8'h7F;
        file_bytes[ds + 8]  = 8'h00;
        file_bytes[ds + 9]  = 8'h00;
        file_bytes[ds + 12] = 8'hFF;
        file_bytes[ds + 13] = 8'hFF;
        send_file(0);
    endtask

    task automatic test_empty_data();
        wav_spec_t s;
        // zero-length data chunk
        s = base_spec(DEPTH_16, 16'd1, 0);
        s.trail = 8'd2;
        build_file(s);
        send_file(0);
        // widest channel count, data shorter than a frame
        s = base_spec(DEPTH_8, 16'hFFFF, 0);
        s.rate      = 32'd0;
        s.data_size = 32'd1;
        s.data_len  = 32'd1;
        s.trail     = 8'd2;
        build_file(s);
        send_file(0);
    endtask

    task automatic test_header_errors();
        wav_spec_t s;
        int        c;
        for (c = 0; c < 12; c++) begin
            s = base_spec(DEPTH_16, 16'd1, 2);
            case (c)
                0: s.riff_tag = TAG_RIFF ^ 32'h0000_0001;
                1: s.wave_tag = 32'h5741_5646;
                2: s.fmt_tag  = 32'h666D_7421;
                3: s.format   = 16'd3;
                4: s.format   = 16'hFFFE;
                5: s.bits     = 16'd12;
                6: s.bits     = 16'd0;
                7: s.chans    = 16'd0;
                8: s.fmt_size = 32'd15;
                // several faults at once: the higher-priority one must be reported
                9: begin
                    s.riff_tag = 32'h0000_0000;
                    s.format   = 16'd3;
                    s.chans    = 16'd0;
                end
                10: begin
                    s.format = 16'd3;
                    s.chans  = 16'd0;
                end
                default: begin
                    s.chans    = 16'd0;
                    s.fmt_size = 32'd0;
                end
            endcase
            build_file(s);
            send_file(0);
        end
    endtask

    task automatic test_truncation();
        wav_spec_t s;
        int        cuts[9];
        int        i;
        // header, last header byte, chunk header, data header end, first-channel
        // high byte, second channel, later frame
        cuts = '{1, 20, 36, 40, 44, 45, 46, 47, 50};
        s = base_spec(DEPTH_16, 16'd2, 3);
        build_file(s);
        for (i = 0; i < 9; i++)
            send_file(cuts[i]);
        // header fault on the same byte as end_of_file keeps the fault
        s.riff_tag = 32'h5249_4647;
        build_file(s);
        send_file(HDR_LAST + 1);
        // end of file while skipping extra fmt bytes
        s = base_spec(DEPTH_8, 16'd1, 3);
        s.fmt_size  = 32'd20;
        s.extra_fmt = 8'd4;
        build_file(s);
        send_file(38);
        // end of file on an 8-bit sample byte
        s = base_spec(DEPTH_8, 16'd1, 3);
        build_file(s);
        send_file(45);
    endtask

    task automatic test_backpressure();
        wav_spec_t s;
        s = base_spec(DEPTH_8, 16'd1, 40);
        build_file(s);
        stall_hold = 120;
        send_file(0);
    endtask

    task automatic test_random_files();
        wav_spec_t   s;
        int          start;
        int          pick;
        int          cut;
        int          n;
        logic [15:0] bits;
        logic [15:0] chans;
        logic [31:0] frame;
        start = bytes_sent;
        while (bytes_sent - start < 200) begin
            bits = $urandom_range(1) ? DEPTH_16 : DEPTH_8;
            pick = $urandom_range(9);
            if (pick < 5)
                chans = 16'd1;
            else if (pick < 8)
                chans = 16'd2;
            else
                chans = 16'($urandom_range(8, 3));
            s = base_spec(bits, chans, $urandom_range(24));
            frame = {16'd0, bits >> 3} * {16'd0, chans};
            if (frame > 1 && $urandom_range(2) == 0)
                s.data_size = s.data_size + $urandom_range(frame - 1);
            s.data_len = s.data_size;
            if ($urandom_range(3) == 0) begin
                s.extra_fmt = 8'($urandom_range(4, 1));
                s.fmt_size  = s.fmt_size + s.extra_fmt;
            end
            if ($urandom_range(1))
                s.n_fill = 8'($urandom_range(2, 1));
            s.zero_chunk = ($urandom_range(7) == 0);
            if ($urandom_range(2) == 0)
                s.trail = 8'($urandom_range(3, 1));
            cut  = 0;
            pick = $urandom_range(19);
            if (pick == 13 || pick == 14) begin
                case ($urandom_range(7))
                    0: s.riff_tag = s.riff_tag ^ (32'd1 << $urandom_range(31));
                    1: s.wave_tag = s.wave_tag ^ (32'd1 << $urandom_range(31));
                    2: s.fmt_tag  = s.fmt_tag ^ (32'd1 << $urandom_range(31));
                    3: s.format   = 16'($urandom);
                    4: s.bits     = $urandom_range(1) ? 16'($urandom)
                                                      : 16'($urandom_range(32));
                    5: s.chans    = 16'd0;
                    6: begin
                        s.fmt_size  = $urandom_range(15);
                        s.extra_fmt = 8'd0;
                    end
                    default: s.fmt_size = $urandom | 32'h8000_0000;
                endcase
            end else if (pick == 17) begin
                if ($urandom_range(1)) begin
                    s.huge_fill = 1'b1;
                end else begin
                    s.data_size = $urandom | 32'h8000_0000;
                    s.data_len  = $urandom_range(30);
                end
            end
            build_file(s);
            if (pick == 15 || pick == 16) begin
                cut = $urandom_range(file_bytes.size(), 1);
            end else if (pick == 18) begin
                file_bytes.delete();
                repeat ($urandom_range(40, 1)) file_bytes.push_back(8'($urandom));
            end else if (pick == 19) begin
                n = $urandom_range(file_bytes.size() - 1);
                file_bytes[n] = file_bytes[n] ^ (8'd1 << $urandom_range(7));
            end
            send_file(cut);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: kind %0d", o_kind);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("sample", 32'(want.sample), 32'($unsigned(o_sample)));
                check_field("last_sample", 32'(want.last_sample), 32'(o_last_sample));
                check_field("sample_rate", want.sample_rate, o_sample_rate);
                check_field("channel_count", 32'(want.channel_count), 32'(o_channel_count));
                check_field("bit_depth", 32'(want.bit_depth), 32'(o_bit_depth));
                check_field("error_code", 32'(want.error_code), 32'(o_error_code));
            end
            results_seen++;
        end
    end

    // Result-side stall: a long hold when asked, else a mode that changes now and then.
    always @(negedge i_clk) begin
        rx_tick++;
        if (stall_hold > 0) begin
            i_stall <= 1'b1;
            stall_hold--;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(3));
                rx_left = $urandom_range(200, 20);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:    i_stall <= 1'b0;
                RX_RANDOM:  i_stall <= ($urandom_range(2) == 0);
                RX_PATTERN: i_stall <= (rx_tick % 5 < 2);
                default:    i_stall <= ($urandom_range(3) != 0);
            endcase
        end
    end

    initial begin
        model_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pcm8_mono();
        test_pcm16_stereo();
        test_empty_data();
        test_header_errors();
        test_truncation();
        test_backpressure();
        test_random_files();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d files in %0d bytes, %0d results checked", files_sent,
                 bytes_sent, results_seen);
        $display("  format %0d, samples %0d, errors %0d, empty data %0d",
                 n_kind[KIND_FORMAT], n_kind[KIND_SAMPLE], n_kind[KIND_ERROR],
                 n_kind[KIND_EMPTY]);
        if (fail_count == 0)
            $display("wav_pcm_stream_parser_tb: PASS");
        else
            $display("wav_pcm_stream_parser_tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("wav_pcm_stream_parser_tb: FAIL");
        $finish;
    end

endmodule
